[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, ignored while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/bf3_pkg.sv]
package bf3_pkg;

  localparam int CHAN_W = 8;
  localparam int NUM_CHAN = 3;
  localparam int DIM_W = 9;
  localparam int COORD_W = 8;

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;
  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RESET = 9'd160;
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RESET = 9'd120;

  // window sum and divide by nine: floor(s / 9) == (s * 7282) >> 16 for s < 2296
  localparam int SUM_W = 12;
  localparam int MUL_W = 13;
  localparam int PROD_W = SUM_W + MUL_W;
  localparam logic [MUL_W-1:0] DIV9_MUL = 13'd7282;
  localparam int DIV9_SHIFT = 16;

  localparam int QUEUE_DEPTH = 4;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pix_t;

  typedef struct packed {
    logic              start_of_frame;
    logic [CHAN_W-1:0] chan0;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan2;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  mean_chan0;
    logic [CHAN_W-1:0]  mean_chan1;
    logic [CHAN_W-1:0]  mean_chan2;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic               last_of_frame;
  } out_word_t;

  // classified pixel handed from the front to the back
  typedef struct packed {
    pix_t               pix;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic               emit;
    logic               last;
  } job_t;

  // one line store entry: line two above and line one above
  typedef struct packed {
    pix_t upper;
    pix_t lower;
  } line_pair_t;

endpackage

[rtl/bf3_front.sv]
module bf3_front #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256,
  localparam int AW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [bf3_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bf3_pkg::DIM_W-1:0]        cfg_data,
  input  logic                             pixel_valid,
  output logic                             pixel_ready,
  input  bf3_pkg::in_word_t                pixel,
  input  logic                             queue_full,
  output logic                             push,
  output bf3_pkg::job_t                    job,
  output logic [AW-1:0]                    addr
);

  localparam int CMPW = ((AW > bf3_pkg::DIM_W) ? AW : bf3_pkg::DIM_W) + 1;
  localparam int CMPH = ((RW > bf3_pkg::DIM_W) ? RW : bf3_pkg::DIM_W) + 1;

  logic [bf3_pkg::DIM_W-1:0] image_width;
  logic [bf3_pkg::DIM_W-1:0] image_height;
  logic [AW-1:0] col;
  logic [RW-1:0] row;
  logic [AW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic [AW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic [CMPW-1:0] w_raw, w_eff, c_ext, c_inc, c_dec;
  logic [CMPH-1:0] h_raw, h_eff, r_ext, r_inc, r_dec;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= bf3_pkg::IMAGE_WIDTH_RESET;
      image_height <= bf3_pkg::IMAGE_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bf3_pkg::CFG_IMAGE_WIDTH: image_width <= cfg_data;
        bf3_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp frame size into the supported range
  always_comb begin
    w_raw = CMPW'(image_width);
    h_raw = CMPH'(image_height);
    if (w_raw < CMPW'(3)) w_eff = CMPW'(3);
    else if (w_raw > CMPW'(MAX_WIDTH)) w_eff = CMPW'(MAX_WIDTH);
    else w_eff = w_raw;
    if (h_raw < CMPH'(3)) h_eff = CMPH'(3);
    else if (h_raw > CMPH'(MAX_HEIGHT)) h_eff = CMPH'(MAX_HEIGHT);
    else h_eff = h_raw;
  end

  // position of the incoming pixel and its classification
  always_comb begin
    col_cur = pixel.start_of_frame ? '0 : col;
    row_cur = pixel.start_of_frame ? '0 : row;
    c_ext = CMPW'(col_cur);
    r_ext = CMPH'(row_cur);
    c_inc = c_ext + CMPW'(1);
    r_inc = r_ext + CMPH'(1);
    c_dec = c_ext - CMPW'(1);
    r_dec = r_ext - CMPH'(1);

    job.pix = {pixel.chan2, pixel.chan1, pixel.chan0};
    job.out_col = c_dec[bf3_pkg::COORD_W-1:0];
    job.out_row = r_dec[bf3_pkg::COORD_W-1:0];
    job.emit = (c_ext >= CMPW'(2)) && (r_ext >= CMPH'(2)) && (c_ext < w_eff) && (r_ext < h_eff);
    job.last = (c_inc == w_eff) && (r_inc == h_eff);
    addr = col_cur;

    if (c_inc >= w_eff) begin
      col_next = '0;
      row_next = (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
    end else begin
      col_next = c_inc[AW-1:0];
      row_next = row_cur;
    end
  end

  assign pixel_ready = !queue_full;
  assign push = pixel_valid && pixel_ready;

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (push) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

[rtl/bf3_queue.sv]
module bf3_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  output logic              head_valid,
  output logic [DATA_W-1:0] head_data,
  input  logic              pop
);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10: count <= count + CW'(1);
        2'b01: count <= count - CW'(1);
        default: ;
      endcase
    end
  end

endmodule

[rtl/bf3_back.sv]
module bf3_back #(
  parameter int MAX_WIDTH = 256,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  bf3_pkg::job_t       head_job,
  input  logic [AW-1:0]       head_addr,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_ready,
  output bf3_pkg::out_word_t  result
);

  localparam int NC = bf3_pkg::NUM_CHAN;

  bf3_pkg::line_pair_t line_mem [MAX_WIDTH];

  logic advance;
  logic s1_valid;
  bf3_pkg::job_t s1_job;
  logic [AW-1:0] s1_addr;
  bf3_pkg::line_pair_t rd_q;
  bf3_pkg::line_pair_t fwd_data;
  logic fwd_hit;
  bf3_pkg::line_pair_t rd;
  bf3_pkg::line_pair_t wr;
  bf3_pkg::pix_t win [6];
  bf3_pkg::pix_t colv [3];
  logic [bf3_pkg::SUM_W-1:0] sum_next [NC];
  logic s2_valid;
  logic [bf3_pkg::SUM_W-1:0] s2_sum [NC];
  logic [bf3_pkg::COORD_W-1:0] s2_col;
  logic [bf3_pkg::COORD_W-1:0] s2_row;
  logic s2_last;
  logic [bf3_pkg::PROD_W-1:0] prod [NC];
  logic [bf3_pkg::CHAN_W-1:0] mean [NC];

  // whole back pipeline moves unless a result waits at the output
  assign advance = !result_valid || result_ready;
  assign pop = advance && head_valid;

  // read data, with forwarding of a write to the same entry in the same cycle
  always_comb begin
    rd = fwd_hit ? fwd_data : rd_q;
    colv[0] = rd.upper;
    colv[1] = rd.lower;
    colv[2] = s1_job.pix;
    wr.upper = rd.lower;
    wr.lower = s1_job.pix;
  end

  // nine-pixel sums per channel
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      sum_next[c] = '0;
      for (int k = 0; k < 6; k++) begin
        sum_next[c] = sum_next[c] + bf3_pkg::SUM_W'(win[k][c]);
      end
      for (int k = 0; k < 3; k++) begin
        sum_next[c] = sum_next[c] + bf3_pkg::SUM_W'(colv[k][c]);
      end
    end
  end

  // line store: read for the incoming word, write back for the word in stage one
  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      line_mem[s1_addr] <= wr;
    end
    if (pop) begin
      rd_q <= line_mem[head_addr];
      fwd_data <= wr;
    end
  end

  // stage one: item whose line store entry is being read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else if (advance) begin
      s1_valid <= pop;
      if (pop) begin
        fwd_hit <= s1_valid && (head_addr == s1_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_job <= head_job;
      s1_addr <= head_addr;
    end
  end

  // window columns: two columns behind the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 6; k++) begin
        win[k] <= '0;
      end
    end else if (advance && s1_valid) begin
      for (int k = 0; k < 3; k++) begin
        win[k] <= win[k + 3];
        win[k + 3] <= colv[k];
      end
    end
  end

  // stage two: registered sums
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid && s1_job.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_sum <= sum_next;
      s2_col <= s1_job.out_col;
      s2_row <= s1_job.out_row;
      s2_last <= s1_job.last;
    end
  end

  // divide by nine through the reciprocal
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      prod[c] = bf3_pkg::PROD_W'(s2_sum[c]) * bf3_pkg::PROD_W'(bf3_pkg::DIV9_MUL);
      mean[c] = prod[c][bf3_pkg::DIV9_SHIFT +: bf3_pkg::CHAN_W];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.mean_chan0 <= mean[0];
      result.mean_chan1 <= mean[1];
      result.mean_chan2 <= mean[2];
      result.out_col <= s2_col;
      result.out_row <= s2_row;
      result.last_of_frame <= s2_last;
    end
  end

endmodule

[rtl/box_filter_3x3_rgb.sv]
// 3x3 box filter over an RGB pixel stream in raster order. Each accepted
// pixel word (three 8-bit channels, start_of_frame on the first pixel of a
// frame) is placed by the front part, which keeps the column and row counters
// and the frame size registers, and queued for the back part. The back part
// holds the two previous lines in one line store memory (MAX_WIDTH entries of
// two pixels, one read and one write port) and the two previous window
// columns, and for every interior pixel returns each channel's nine-pixel sum
// divided by nine, with the centre's coordinates and a flag on the last
// interior pixel of the frame. Border pixels give no result word. Sustained
// rate is one pixel per clock while the result side does not stall; a
// result word passes the queue slot, the line store access and the sum and
// divide stages before it leaves. A four-word queue between front and back
// absorbs back pressure from the result side. The line store needs no
// clearing after reset: window positions that would read unwritten entries
// fall on the frame border.
module box_filter_3x3_rgb #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [bf3_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bf3_pkg::DIM_W-1:0]        cfg_data,
  input  logic                             pixel_valid,
  output logic                             pixel_ready,
  input  bf3_pkg::in_word_t                pixel,
  output logic                             result_valid,
  input  logic                             result_ready,
  output bf3_pkg::out_word_t               result
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int QW = AW + $bits(bf3_pkg::job_t);

  logic queue_full;
  logic push;
  bf3_pkg::job_t job;
  logic [AW-1:0] addr;
  logic head_valid;
  logic [QW-1:0] head_data;
  bf3_pkg::job_t head_job;
  logic [AW-1:0] head_addr;
  logic pop;

  // classification and position tracking
  bf3_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel(pixel),
    .queue_full(queue_full),
    .push(push),
    .job(job),
    .addr(addr)
  );

  // queue between front and back
  bf3_queue #(
    .DATA_W(QW),
    .DEPTH(bf3_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data({addr, job}),
    .full(queue_full),
    .head_valid(head_valid),
    .head_data(head_data),
    .pop(pop)
  );

  assign head_addr = head_data[QW-1 -: AW];
  assign head_job = head_data[$bits(bf3_pkg::job_t)-1:0];

  // line store, window and arithmetic
  bf3_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .head_valid(head_valid),
    .head_job(head_job),
    .head_addr(head_addr),
    .pop(pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

endmodule

[rtl/bf3_checker.sv]
`include "assert_macros.svh"

module bf3_checker (
  input logic                clk,
  input logic                rst,
  input logic                pixel_ready,
  input logic                result_valid,
  input logic                result_ready,
  input bf3_pkg::out_word_t  result
);

  // a waiting result word stays and keeps its contents
  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result))

  // nothing comes out straight after reset
  `ASSERT_NEXT_ALWAYS(a_reset_no_result, clk, rst, !result_valid)

  // the input side is open straight after reset
  `ASSERT_NEXT_ALWAYS(a_reset_ready, clk, rst, pixel_ready)

  // input back pressure only follows a stalled result word
  `ASSERT_IMPLY(a_stall_cause, clk, rst, !pixel_ready, $past(result_valid && !result_ready))

endmodule

bind box_filter_3x3_rgb bf3_checker u_bf3_checker (
  .clk(clk),
  .rst(rst),
  .pixel_ready(pixel_ready),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result(result)
);
